// ----- src/acsa_pkg.sv -----
`default_nettype none

package acsa_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W   = 10;
    localparam int VALUE_W    = 10;
    localparam int CHAN_W     = 4;
    localparam int KIND_W     = 2;
    localparam int MODE_W     = 2;
    localparam int CNT_W      = 8;
    localparam int SUM_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE   = 2'd1;

    // Output mode codes. The unused code behaves as MODE_NONE.
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AVG  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RAW  = 2'd2;

    // Result kind codes.
    localparam logic [KIND_W-1:0] KIND_MUX = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AVG = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RAW = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CNT_W-1:0]  RESET_AVERAGE_COUNT = 8'd50;
    localparam logic [MODE_W-1:0] RESET_OUTPUT_MODE   = MODE_AVG;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 10'h3ff;

endpackage

`default_nettype wire

// ----- src/acsa_ram.sv -----
`default_nettype none

module acsa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/acsa_div.sv -----
`default_nettype none

module acsa_div
    import acsa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic      [SUM_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [STEP_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              ge;

    // One restoring step per cycle: the remainder takes the next dividend bit
    // and the divisor is subtracted when it fits.
    assign shifted = {r_rem, r_q[SUM_W-1]};
    assign ge      = shifted >= {1'b0, r_dvs};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= STEP_W'(SUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[SUM_W-2:0], ge};
            r_rem <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

// ----- src/adc_channel_scan_averager.sv -----
`default_nettype none

// Round-robin ADC scan controller with oversampling average. Each input
// transaction carries one finished conversion for the channel currently
// selected; the block stores it as that channel's latest value, steps to the
// next channel and returns a mux-select result (kind 0) naming the channel to
// convert next. A sample that needs no further work leaves the block idle,
// and the next one can be taken as soon as the output register is free. When
// the sample for the highest channel completes a sweep, the block goes busy
// and walks the channels one at a time: in raw mode it returns every latest
// value, in averaged mode it adds the sweep into per-channel sums held in a
// small RAM. Once the configured number of sweeps has been summed, each sum
// goes through a shared bit-serial divider, one quotient bit per cycle, so a
// channel passes through read, start, the divider and emit, and each emit
// waits while the downstream side holds ready low. Quotients above the 10-bit
// range saturate at full scale. The final result of every input transaction
// carries last. An average count of zero acts as one; output mode three
// behaves as mode zero. Configuration is written through a plain write port
// and should only change while the block is idle.
module adc_channel_scan_averager
    import acsa_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input transactions.
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    // Result transactions.
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [KIND_W-1:0]     o_kind,
    output logic      [CHAN_W-1:0]     o_channel,
    output logic      [VALUE_W-1:0]    o_value,
    output logic                       o_last,
    // Configuration writes.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    // Sequencer: IDLE takes samples; the other states walk the channels
    // after a sweep ends.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_ACC  = 5'b00100,
        S_DIV  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [CNT_W-1:0]  r_avg_cnt;
    logic [MODE_W-1:0] r_mode;

    // Scan and averaging state.
    logic [IDX_W-1:0]        r_chan, n_chan;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_sweep_cnt, n_sweep_cnt;
    logic [NUM_CHANNELS-1:0] r_sum_vld, n_sum_vld;
    logic                    r_avg, n_avg;
    logic                    r_emit, n_emit;

    // Output register.
    logic               r_out_vld, n_out_vld;
    logic [KIND_W-1:0]  r_kind, n_kind;
    logic [CHAN_W-1:0]  r_ochan, n_ochan;
    logic [VALUE_W-1:0] r_value, n_value;
    logic               r_last, n_last;

    // Datapath.
    logic               in_acc;
    logic               out_free;
    logic               sweep_end;
    logic [CNT_W-1:0]   divisor;
    logic [CNT_W-1:0]   new_cnt;
    logic               emit_now;
    logic               more;
    logic               lat_we;
    logic               sum_we;
    logic [VALUE_W-1:0] lat_rd;
    logic [SUM_W-1:0]   sum_rd;
    logic [SUM_W-1:0]   sum_new;
    logic               div_start;
    logic               div_busy;
    logic [SUM_W-1:0]   quot;
    logic [VALUE_W-1:0] quot_sat;
    logic [IDX_W+CHAN_W-1:0] next_chan_ext;
    logic [IDX_W+CHAN_W-1:0] idx_ext;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_vld || i_out_ready;

    assign sweep_end = r_chan == LAST_IDX;
    assign n_chan    = sweep_end ? '0 : r_chan + 1'b1;
    assign divisor   = (r_avg_cnt == '0) ? CNT_W'(1) : r_avg_cnt;
    assign new_cnt   = r_sweep_cnt + 1'b1;
    assign emit_now  = new_cnt >= divisor;
    assign more      = sweep_end &&
                       (r_mode == MODE_RAW || (r_mode == MODE_AVG && emit_now));

    // The sum of a channel that was never written since the last clear is zero.
    assign sum_new  = (r_sum_vld[r_idx] ? sum_rd : '0) +
                      {{(SUM_W-VALUE_W){1'b0}}, lat_rd};
    assign quot_sat = (quot > SUM_W'(VALUE_MAX)) ? VALUE_MAX : quot[VALUE_W-1:0];

    // Channel numbers are reported in the low bits of the channel field.
    assign next_chan_ext = {{CHAN_W{1'b0}}, n_chan};
    assign idx_ext       = {{CHAN_W{1'b0}}, r_idx};

    assign o_in_ready = (r_state == S_IDLE) && out_free;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_sweep_cnt = r_sweep_cnt;
        n_sum_vld   = r_sum_vld;
        n_avg       = r_avg;
        n_emit      = r_emit;
        n_out_vld   = r_out_vld && !i_out_ready;
        n_kind      = r_kind;
        n_ochan     = r_ochan;
        n_value     = r_value;
        n_last      = r_last;
        lat_we      = 1'b0;
        sum_we      = 1'b0;
        div_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    lat_we    = 1'b1;
                    n_out_vld = 1'b1;
                    n_kind    = KIND_MUX;
                    n_ochan   = next_chan_ext[CHAN_W-1:0];
                    n_value   = '0;
                    n_last    = !more;
                    n_idx     = '0;
                    if (sweep_end && r_mode == MODE_RAW) begin
                        n_avg   = 1'b0;
                        n_emit  = 1'b0;
                        n_state = S_RD;
                    end else if (sweep_end && r_mode == MODE_AVG) begin
                        n_avg       = 1'b1;
                        n_emit      = emit_now;
                        n_sweep_cnt = emit_now ? '0 : new_cnt;
                        n_state     = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = r_avg ? S_ACC : S_EMIT;
            end
            S_ACC: begin
                if (r_emit) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    sum_we           = 1'b1;
                    n_sum_vld[r_idx] = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_DIV: begin
                if (!div_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_kind    = r_avg ? KIND_AVG : KIND_RAW;
                    n_ochan   = idx_ext[CHAN_W-1:0];
                    n_value   = r_avg ? quot_sat : lat_rd;
                    n_last    = r_idx == LAST_IDX;
                    if (r_idx == LAST_IDX) begin
                        n_state = S_IDLE;
                        if (r_avg) begin
                            n_sum_vld = '0;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chan      <= '0;
            r_idx       <= '0;
            r_sweep_cnt <= '0;
            r_sum_vld   <= '0;
            r_avg       <= 1'b0;
            r_emit      <= 1'b0;
            r_out_vld   <= 1'b0;
            r_avg_cnt   <= RESET_AVERAGE_COUNT;
            r_mode      <= RESET_OUTPUT_MODE;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_sweep_cnt <= n_sweep_cnt;
            r_sum_vld   <= n_sum_vld;
            r_avg       <= n_avg;
            r_emit      <= n_emit;
            r_out_vld   <= n_out_vld;
            if (in_acc) begin
                r_chan <= n_chan;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_AVERAGE_COUNT: r_avg_cnt <= i_cfg_data[CNT_W-1:0];
                    REG_OUTPUT_MODE:   r_mode    <= i_cfg_data[MODE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result payload needs no reset; it is qualified by r_out_vld.
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_ochan <= n_ochan;
        r_value <= n_value;
        r_last  <= n_last;
    end

    assign o_out_valid = r_out_vld;
    assign o_kind      = r_kind;
    assign o_channel   = r_ochan;
    assign o_value     = r_value;
    assign o_last      = r_last;

    // Latest conversion per channel. Every channel is written during a sweep
    // before the sweep end reads it, so this store needs no valid bits.
    acsa_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NUM_CHANNELS)
    ) u_latest (
        .i_clk   (i_clk),
        .i_we    (lat_we),
        .i_waddr (r_chan),
        .i_wdata (i_sample[VALUE_W-1:0]),
        .i_raddr (r_idx),
        .o_rdata (lat_rd)
    );

    // Per-channel running sums, qualified by r_sum_vld.
    acsa_ram #(
        .WIDTH (SUM_W),
        .DEPTH (NUM_CHANNELS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (r_idx),
        .i_wdata (sum_new),
        .i_raddr (r_idx),
        .o_rdata (sum_rd)
    );

    acsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_new),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_quotient (quot)
    );

    // A sample that does not end a sweep leaves the sequencer idle.
    a_mid_sweep_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !sweep_end) |=> (r_state == S_IDLE))
        else $error("sequencer left idle on a sample inside a sweep");

    // The shared divider is only started when it has finished its last job.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // While idle with no sweeps counted, no channel may hold a running sum.
    a_sums_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_sweep_cnt == '0) |-> (r_sum_vld == '0))
        else $error("running sums left over after an averaged output");

endmodule

`default_nettype wire

// ----- bench/adc_channel_scan_averager_tb.sv -----
`default_nettype none

// Self-checking bench for the round-robin ADC scan averager. A behavioral
// copy of the scan state (channel pointer, latest codes, per-channel sums and
// the sweep counter) runs alongside the block. Every conversion transaction
// that the block accepts is fed to that copy, which queues the results the
// block must return. A checker on the result side pops that queue on each
// accepted result transaction and compares every field.
module adc_channel_scan_averager_tb
    import acsa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCAN_CHANNELS = 16;
    localparam int LIMIT_CYCLES  = 400_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int TAIL_CYCLES   = 100;
    localparam int IDLE_PERCENT  = 9;
    localparam int TARGET_SAMPLES = 460;

    // Index codes and the mode code that the package does not name. Writes to
    // the spare indexes must be ignored, and the spare mode acts as no output.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_SPARE  = 2'd3;

    // Corner codes for the first sweep: both rails, alternating bits, walking
    // ones and values just inside the rails.
    localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [SCAN_CHANNELS] = '{
        10'h000, 10'h3ff, 10'h155, 10'h2aa, 10'h001, 10'h200, 10'h3fe, 10'h1ff,
        10'h002, 10'h100, 10'h3fd, 10'h0ff, 10'h3ff, 10'h000, 10'h3ff, 10'h3ff
    };

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_scan_result;

    // Block inputs, all known from time zero.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [SAMPLE_W-1:0]   i_sample    = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [KIND_W-1:0]     o_kind;
    logic [CHAN_W-1:0]     o_channel;
    logic [VALUE_W-1:0]    o_value;
    logic                  o_last;

    // Shadow of the block's configuration and scan state.
    logic [CNT_W-1:0]      avg_count;
    logic [MODE_W-1:0]     out_mode;
    logic [CHAN_W-1:0]     next_chan;
    logic [SAMPLE_W-1:0]   latest_code [SCAN_CHANNELS];
    logic [SUM_W-1:0]      chan_sum    [SCAN_CHANNELS];
    logic [CNT_W-1:0]      sweeps_summed;

    t_scan_result          results_due [$];
    int                    mismatches   = 0;
    int                    samples_sent = 0;
    int                    cycle_count  = 0;
    bit                    idle_enabled = 1'b1;

    adc_channel_scan_averager #(
        .NUM_CHANNELS(SCAN_CHANNELS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sample   (i_sample),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_kind     (o_kind),
        .o_channel  (o_channel),
        .o_value    (o_value),
        .o_last     (o_last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or drops a result.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("adc_channel_scan_averager test failed");
            $finish;
        end
    end

    // Push one result onto the queue of results the block still owes.
    function automatic void queue_result(input logic [KIND_W-1:0] kind,
                                         input logic [CHAN_W-1:0] chan,
                                         input logic [VALUE_W-1:0] value,
                                         input logic last);
        t_scan_result r;
        r.kind    = kind;
        r.channel = chan;
        r.value   = value;
        r.last    = last;
        results_due.push_back(r);
    endfunction

    // Apply one accepted conversion to the shadow state and queue what the
    // block must return for it: the mux select first, then, when the sweep
    // ends with values due, the channel values in ascending order.
    function automatic void apply_conversion(input logic [SAMPLE_W-1:0] code);
        logic [CHAN_W-1:0] chan;
        logic              sweep_done;
        logic              emit_values;
        int unsigned       divisor;
        int unsigned       quotient;
        logic [CNT_W-1:0]  summed;
        chan = next_chan;
        latest_code[chan] = code;
        sweep_done = (chan == CHAN_W'(SCAN_CHANNELS - 1));
        next_chan  = sweep_done ? '0 : chan + 1'b1;
        // A zero count divides as one.
        divisor = (avg_count == '0) ? 1 : avg_count;
        summed  = sweeps_summed + 1'b1;
        emit_values = sweep_done &&
            (out_mode == MODE_RAW || (out_mode == MODE_AVG && summed >= divisor));
        queue_result(KIND_MUX, next_chan, '0, !emit_values);
        if (!sweep_done) begin
            return;
        end
        if (out_mode == MODE_RAW) begin
            for (int i = 0; i < SCAN_CHANNELS; i++) begin
                queue_result(KIND_RAW, CHAN_W'(i), latest_code[i],
                             i == SCAN_CHANNELS - 1);
            end
        end else if (out_mode == MODE_AVG) begin
            // The sums and the sweep counter only move in averaged mode.
            for (int i = 0; i < SCAN_CHANNELS; i++) begin
                chan_sum[i] = chan_sum[i] + latest_code[i];
            end
            sweeps_summed = summed;
            if (emit_values) begin
                for (int i = 0; i < SCAN_CHANNELS; i++) begin
                    quotient = chan_sum[i] / divisor;
                    // A count lowered mid-batch can push a quotient past
                    // full scale, which clips to the top code.
                    if (quotient > VALUE_MAX) begin
                        quotient = VALUE_MAX;
                    end
                    queue_result(KIND_AVG, CHAN_W'(i), VALUE_W'(quotient),
                                 i == SCAN_CHANNELS - 1);
                    chan_sum[i] = '0;
                end
                sweeps_summed = '0;
            end
        end
    endfunction

    // Result side: compare each accepted result transaction with the oldest
    // result still owed, then pick the ready level for the next cycle.
    always @(posedge i_clk) begin
        t_scan_result want;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: kind %0d channel %0d value %0d last %0d",
                           o_kind, o_channel, o_value, o_last);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (o_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, o_kind);
                        mismatches++;
                    end
                    if (o_channel !== want.channel) begin
                        $error("channel: expected %0d, got %0d", want.channel, o_channel);
                        mismatches++;
                    end
                    if (o_value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, o_value);
                        mismatches++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        mismatches++;
                    end
                end
            end
            i_out_ready <= !(idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Send one conversion transaction. Valid is left high on return so that
    // back-to-back transactions need no gap; anything that waits afterwards
    // lowers it first.
    task automatic send_sample(input logic [SAMPLE_W-1:0] code);
        while (idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= code;
        do begin
            @(posedge i_clk);
        end while (o_in_ready !== 1'b1);
        apply_conversion(code);
        samples_sent++;
    endtask

    // Random code, with the rails over-weighted.
    function automatic logic [SAMPLE_W-1:0] pick_code();
        logic [SAMPLE_W-1:0] code;
        code = SAMPLE_W'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                code = '0;
            end
            1, 2: begin
                code = '1;
            end
            default: begin
            end
        endcase
        return code;
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_sample(pick_code());
        end
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Drain, then give the block time to finish any housekeeping so that a
    // register write finds it idle.
    task automatic settle_block();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The write enable is raised for the write and then held low before the
    // task returns, so that writes issued back to back stay apart.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == REG_AVERAGE_COUNT) begin
            avg_count = data;
        end else if (index == REG_OUTPUT_MODE) begin
            out_mode = data[MODE_W-1:0];
        end
        @(posedge i_clk);
    endtask

    // Mode writes carry random upper data bits, which the block must drop.
    task automatic write_mode(input logic [MODE_W-1:0] mode);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[MODE_W-1:0] = mode;
        write_reg(REG_OUTPUT_MODE, data);
    endtask

    // Reset configuration: averaged mode over 50 sweeps, so the corner sweep
    // only feeds the sums and yields mux selects alone.
    task automatic test_reset_defaults();
        for (int i = 0; i < SCAN_CHANNELS; i++) begin
            send_sample(EDGE_SAMPLES[i]);
        end
    endtask

    // Drop the count to the number of sweeps already summed. The next sweep end
    // must emit at once, and the doubled full-scale sums must clip.
    task automatic test_lowered_count();
        settle_block();
        write_reg(REG_AVERAGE_COUNT, 8'd1);
        for (int i = 0; i < SCAN_CHANNELS; i++) begin
            send_sample(i[0] ? pick_code() : '1);
        end
    endtask

    task automatic test_raw_mode();
        settle_block();
        write_mode(MODE_RAW);
        send_random(3 * SCAN_CHANNELS + 5);
    endtask

    // Neither mode zero nor the spare mode may emit values or touch the sums;
    // writes to the spare indexes change nothing either.
    task automatic test_quiet_modes();
        settle_block();
        write_mode(MODE_NONE);
        send_random(20);
        settle_block();
        write_mode(MODE_SPARE);
        write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
        send_random(20);
    endtask

    // A zero count behaves as one: every sweep end emits its own values.
    task automatic test_zero_count();
        settle_block();
        write_reg(REG_AVERAGE_COUNT, 8'd0);
        write_mode(MODE_AVG);
        send_random(2 * SCAN_CHANNELS);
    endtask

    // Largest count: two sweeps summed, then the count cut to three so the
    // batch closes on the third sweep.
    task automatic test_longest_batch();
        settle_block();
        write_reg(REG_AVERAGE_COUNT, 8'd255);
        send_random(2 * SCAN_CHANNELS);
        settle_block();
        write_reg(REG_AVERAGE_COUNT, 8'd3);
        send_random(SCAN_CHANNELS);
    endtask

    // A stretch with no idling on either side: full-rate conversions and a
    // result side that never stalls.
    task automatic test_full_rate();
        settle_block();
        idle_enabled = 1'b0;
        write_reg(REG_AVERAGE_COUNT, 8'd1);
        write_mode(MODE_AVG);
        send_random(2 * SCAN_CHANNELS);
        settle_block();
        write_mode(MODE_RAW);
        send_random(2 * SCAN_CHANNELS);
        settle_block();
        idle_enabled = 1'b1;
    endtask

    // The sender stops mid-sweep until every owed result is back, then
    // carries on with the same configuration.
    task automatic test_pause_mid_sweep();
        settle_block();
        write_reg(REG_AVERAGE_COUNT, 8'd2);
        write_mode(MODE_AVG);
        send_random(7);
        drain_results();
        send_random(41);
    endtask

    // Random phases of random length, mostly averaged with small counts or
    // raw, now and then a quiet mode or an unchanged configuration.
    task automatic test_random_phases();
        int pick;
        while (samples_sent < TARGET_SAMPLES) begin
            settle_block();
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                write_mode(MODE_NONE);
            end else if (pick == 1) begin
                write_mode(MODE_SPARE);
            end else if (pick <= 4) begin
                write_mode(MODE_RAW);
            end else if (pick <= 8) begin
                write_reg(REG_AVERAGE_COUNT, CFG_DATA_W'($urandom_range(0, 4)));
                write_mode(MODE_AVG);
            end
            send_random($urandom_range(8, 40));
        end
    endtask

    initial begin
        avg_count     = RESET_AVERAGE_COUNT;
        out_mode      = RESET_OUTPUT_MODE;
        next_chan     = '0;
        sweeps_summed = '0;
        for (int i = 0; i < SCAN_CHANNELS; i++) begin
            latest_code[i] = '0;
            chan_sum[i]    = '0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_lowered_count();
        test_raw_mode();
        test_quiet_modes();
        test_zero_count();
        test_longest_batch();
        test_full_rate();
        test_pause_mid_sweep();
        test_random_phases();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("adc_channel_scan_averager test passed");
        end else begin
            $display("adc_channel_scan_averager test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
src/acsa_pkg.sv
src/acsa_ram.sv
src/acsa_div.sv
src/adc_channel_scan_averager.sv
bench/adc_channel_scan_averager_tb.sv
